/* sv/blq_pkg.sv */
// Shared types, constants and helpers for the bounded loss queue server.
// No dependencies; every other file imports this package.
package blq_pkg;

   localparam int DEPTH        = 16;
   localparam int IDX_BITS     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SERVICE_BITS = 8;
   localparam int COUNT_BITS   = 32;
   localparam int FRAC_BITS    = 8;
   localparam int WAIT_BITS    = 5;
   localparam int LIMIT_BITS   = 5;
   localparam int AVG_BITS     = 13;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(3);

   typedef enum logic {
      CMD_TICK    = 1'b0,
      CMD_ARRIVAL = 1'b1
   } cmd_type;

   typedef struct packed {
      logic                    command;
      logic [SERVICE_BITS-1:0] service_time;
   } req_item_type;

   typedef struct packed {
      logic [WAIT_BITS-1:0]  waiting;
      logic                  server_busy;
      logic [COUNT_BITS-1:0] accepted_total;
      logic [COUNT_BITS-1:0] lost_total;
      logic [COUNT_BITS-1:0] served_total;
      logic [AVG_BITS-1:0]   average_length;
      logic                  dropped;
      logic                  finished;
   } rsp_item_type;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      sat_inc = (v == '1) ? v : v + 1'b1;
   endfunction

endpackage

/* sv/blq_if.sv */
// Handshake channels of the bounded loss queue server: request, response, csr.
// Depends on blq_pkg.
interface blq_req_if;
   import blq_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    command;
   logic [SERVICE_BITS-1:0] service_time;
   modport source (output valid, command, service_time, input ready);
   modport sink   (input valid, command, service_time, output ready);
endinterface

interface blq_rsp_if;
   import blq_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [WAIT_BITS-1:0]  waiting;
   logic                  server_busy;
   logic [COUNT_BITS-1:0] accepted_total;
   logic [COUNT_BITS-1:0] lost_total;
   logic [COUNT_BITS-1:0] served_total;
   logic [AVG_BITS-1:0]   average_length;
   logic                  dropped;
   logic                  finished;
   modport source (output valid, waiting, server_busy, accepted_total, lost_total,
                   served_total, average_length, dropped, finished, input ready);
   modport sink   (input valid, waiting, server_busy, accepted_total, lost_total,
                   served_total, average_length, dropped, finished, output ready);
endinterface

interface blq_csr_if;
   import blq_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [LIMIT_BITS-1:0] queue_limit;
   modport source (output valid, queue_limit, input ready);
   modport sink   (input valid, queue_limit, output ready);
endinterface

/* sv/blq_core.sv */
// Queue and server state with the single-pass update for one word.
// Depends on blq_pkg.
module blq_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  blq_pkg::req_item_type           item,
   input  logic [blq_pkg::LIMIT_BITS-1:0]  queue_limit,
   output blq_pkg::rsp_item_type           result
);
   import blq_pkg::*;

   logic [SERVICE_BITS-1:0] job_store_ff [DEPTH];

   logic [IDX_BITS-1:0]     head_ff, head_in;
   logic [IDX_BITS-1:0]     tail_ff, tail_in;
   logic [WAIT_BITS-1:0]    waiting_ff, waiting_in;
   logic                    busy_ff, busy_in;
   logic [SERVICE_BITS-1:0] remaining_ff, remaining_in;
   logic [COUNT_BITS-1:0]   accepted_ff, accepted_in;
   logic [COUNT_BITS-1:0]   lost_ff, lost_in;
   logic [COUNT_BITS-1:0]   served_ff, served_in;
   logic [AVG_BITS-1:0]     average_ff, average_in;

   logic [WAIT_BITS-1:0]    limit_eff;
   logic [SERVICE_BITS-1:0] store_time;
   logic [SERVICE_BITS-1:0] remaining_dec;
   logic [AVG_BITS:0]       average_sum;
   logic                    enqueue;
   logic                    dropped;
   logic                    finished;

   assign limit_eff = (queue_limit > LIMIT_BITS'(DEPTH)) ? WAIT_BITS'(DEPTH)
                                                         : WAIT_BITS'(queue_limit);
   // zero service time still takes one busy tick
   assign store_time    = (item.service_time == '0) ? SERVICE_BITS'(1) : item.service_time;
   assign remaining_dec = (remaining_ff != '0) ? remaining_ff - 1'b1 : remaining_ff;
   assign average_sum   = {1'b0, average_ff}
                        + (AVG_BITS+1)'({waiting_ff, {FRAC_BITS{1'b0}}});

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      waiting_in   = waiting_ff;
      busy_in      = busy_ff;
      remaining_in = remaining_ff;
      accepted_in  = accepted_ff;
      lost_in      = lost_ff;
      served_in    = served_ff;
      average_in   = average_ff;
      enqueue      = 1'b0;
      dropped      = 1'b0;
      finished     = 1'b0;
      if (item.command == CMD_ARRIVAL) begin
         if (waiting_ff >= limit_eff) begin
            lost_in = sat_inc(lost_ff);
            dropped = 1'b1;
         end else begin
            enqueue     = 1'b1;
            tail_in     = (tail_ff == IDX_BITS'(DEPTH-1)) ? '0 : tail_ff + 1'b1;
            waiting_in  = waiting_ff + 1'b1;
            accepted_in = sat_inc(accepted_ff);
         end
      end else if (!busy_ff) begin
         // halve toward the waiting count; the sum never exceeds the field
         average_in = average_sum[AVG_BITS:1];
         if (waiting_ff != '0) begin
            remaining_in = job_store_ff[head_ff];
            head_in      = (head_ff == IDX_BITS'(DEPTH-1)) ? '0 : head_ff + 1'b1;
            waiting_in   = waiting_ff - 1'b1;
            busy_in      = 1'b1;
         end
      end else begin
         remaining_in = remaining_dec;
         if (remaining_dec == '0) begin
            busy_in   = 1'b0;
            served_in = sat_inc(served_ff);
            finished  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         waiting_ff   <= '0;
         busy_ff      <= 1'b0;
         remaining_ff <= '0;
         accepted_ff  <= '0;
         lost_ff      <= '0;
         served_ff    <= '0;
         average_ff   <= '0;
      end else if (step) begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         waiting_ff   <= waiting_in;
         busy_ff      <= busy_in;
         remaining_ff <= remaining_in;
         accepted_ff  <= accepted_in;
         lost_ff      <= lost_in;
         served_ff    <= served_in;
         average_ff   <= average_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && enqueue) begin
         job_store_ff[tail_ff] <= store_time;
      end
   end

   always_comb begin
      result.waiting        = waiting_in;
      result.server_busy    = busy_in;
      result.accepted_total = accepted_in;
      result.lost_total     = lost_in;
      result.served_total   = served_in;
      result.average_length = average_in;
      result.dropped        = dropped;
      result.finished       = finished;
   end

endmodule

/* sv/blq_out_reg.sv */
// Result register driving the response channel; frees itself as it is taken.
// Depends on blq_pkg and blq_rsp_if.
module blq_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  blq_pkg::rsp_item_type data,
   output logic                  can_load,
   blq_rsp_if.source             rsp_chan
);
   import blq_pkg::*;

   logic         valid_ff;
   rsp_item_type data_ff;

   assign can_load = !valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (can_load) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (can_load && load) begin
         data_ff <= data;
      end
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.waiting        = data_ff.waiting;
   assign rsp_chan.server_busy    = data_ff.server_busy;
   assign rsp_chan.accepted_total = data_ff.accepted_total;
   assign rsp_chan.lost_total     = data_ff.lost_total;
   assign rsp_chan.served_total   = data_ff.served_total;
   assign rsp_chan.average_length = data_ff.average_length;
   assign rsp_chan.dropped        = data_ff.dropped;
   assign rsp_chan.finished       = data_ff.finished;

endmodule

/* sv/bounded_loss_queue_server_unit.sv */
// Top level of the bounded loss queue server: input register, core, result register.
// Depends on blq_pkg, blq_if, blq_core and blq_out_reg.
//
//   channel    direction  content
//   req_chan   in         command (tick or arrival), service_time
//   rsp_chan   out        waiting, busy, totals, average, dropped, finished
//   csr_chan   in         queue_limit, always ready
//
// One word per cycle sustained while rsp_chan is ready.
// The whole state update is combinational between the input register and
// the result register, so consecutive words see each other's state at once.
// Reset clears all counters, indexes and the server; queue_limit resets to 3.
// A stalled rsp_chan holds the result register, then the input register, then req.
module bounded_loss_queue_server_unit (
   input  logic    clock,
   input  logic    reset,
   blq_req_if.sink   req_chan,
   blq_rsp_if.source rsp_chan,
   blq_csr_if.sink   csr_chan
);
   import blq_pkg::*;

   logic                  in_valid_ff;
   req_item_type          in_item_ff;
   logic [LIMIT_BITS-1:0] limit_ff;
   logic                  can_load;
   logic                  advance;
   rsp_item_type          result;

   assign advance        = in_valid_ff && can_load;
   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_item_ff.command      <= req_chan.command;
         in_item_ff.service_time <= req_chan.service_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_chan.valid) begin
         limit_ff <= csr_chan.queue_limit;
      end
   end

   blq_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .item        (in_item_ff),
      .queue_limit (limit_ff),
      .result      (result)
   );

   blq_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .data     (result),
      .can_load (can_load),
      .rsp_chan (rsp_chan)
   );

endmodule
